FILE: rtl/core/imm_pkg.sv
`default_nettype none

package imm_pkg;

  // Array bounds
  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 16;
  localparam int MAX_DEPTH = 64;

  // Counter widths (index 0..MAX-1) and size widths (1..MAX)
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEP_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int ROWS_SW  = $clog2(MAX_ROWS + 1);
  localparam int COLS_SW  = $clog2(MAX_COLS + 1);
  localparam int DEPTH_SW = $clog2(MAX_DEPTH + 1);

  // Store geometry
  localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
  localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
  localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int C_AW    = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

  typedef logic [A_AW-1:0] a_addr_t;
  typedef logic [B_AW-1:0] b_addr_t;
  typedef logic [C_AW-1:0] c_addr_t;

  // Operation codes
  typedef logic [2:0] op_t;
  localparam op_t OP_WRITE_A = 3'd0;
  localparam op_t OP_WRITE_B = 3'd1;
  localparam op_t OP_WRITE_C = 3'd2;
  localparam op_t OP_COMPUTE = 3'd3;
  localparam op_t OP_READ_C  = 3'd4;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_ROW_COUNT    = 2'd0;
  localparam cfg_index_t REG_COLUMN_COUNT = 2'd1;
  localparam cfg_index_t REG_INNER_DEPTH  = 2'd2;
  localparam cfg_index_t REG_ACCUM_MODE   = 2'd3;

  // Result codes
  localparam logic KIND_READ    = 1'b0;
  localparam logic KIND_DONE    = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Sizes in use, already clamped
  typedef struct packed {
    logic [ROWS_SW-1:0]  rows;
    logic [COLS_SW-1:0]  cols;
    logic [DEPTH_SW-1:0] depth;
  } dims_t;

  // Tag that travels with each product through the compute pipeline
  typedef struct packed {
    logic    valid;
    logic    first;   // first product of a C entry
    logic    last;    // last product of a C entry
    logic    done;    // last product of the whole compute
    c_addr_t c_addr;
  } walk_tag_t;

  function automatic logic [15:0] clamp_size(logic [6:0] v, logic [15:0] bound);
    logic [15:0] wide;
    wide = {9'd0, v};
    if (v == 7'd0) return 16'd1;
    if (wide > bound) return bound;
    return wide;
  endfunction

  function automatic a_addr_t a_index(logic [15:0] m, logic [15:0] k);
    return a_addr_t'(32'(m) * MAX_DEPTH + 32'(k));
  endfunction

  function automatic b_addr_t b_index(logic [15:0] k, logic [15:0] n);
    return b_addr_t'(32'(k) * MAX_COLS + 32'(n));
  endfunction

  function automatic c_addr_t c_index(logic [15:0] m, logic [15:0] n);
    return c_addr_t'(32'(m) * MAX_COLS + 32'(n));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/imm_ram.sv
`default_nettype none

module imm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Hold read data between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/imm_walk.sv
`default_nettype none

module imm_walk (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire imm_pkg::dims_t    dims,
  output imm_pkg::walk_tag_t     tag,
  output imm_pkg::a_addr_t       a_addr,
  output imm_pkg::b_addr_t       b_addr
);
  import imm_pkg::*;

  logic             busy;
  logic [ROW_W-1:0] m;
  logic [COL_W-1:0] n;
  logic [DEP_W-1:0] k;
  logic             last_m;
  logic             last_n;
  logic             last_k;

  assign last_m = (m == ROW_W'(dims.rows - 1'b1));
  assign last_n = (n == COL_W'(dims.cols - 1'b1));
  assign last_k = (k == DEP_W'(dims.depth - 1'b1));

  always_comb begin
    tag.valid  = busy;
    tag.first  = (k == '0);
    tag.last   = last_k;
    tag.done   = last_k && last_n && last_m;
    tag.c_addr = c_index(16'(m), 16'(n));
    a_addr     = a_index(16'(m), 16'(k));
    b_addr     = b_index(16'(k), 16'(n));
  end

  // Walk k innermost, then n, then m
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      m    <= '0;
      n    <= '0;
      k    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      m    <= '0;
      n    <= '0;
      k    <= '0;
    end else if (busy) begin
      if (last_k) begin
        k <= '0;
        if (last_n) begin
          n <= '0;
          if (last_m) begin
            busy <= 1'b0;
          end else begin
            m <= m + 1'b1;
          end
        end else begin
          n <= n + 1'b1;
        end
      end else begin
        k <= k + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/int8_matrix_multiply.sv
// int8_matrix_multiply: C = A x B (or C += A x B) with A unsigned 8-bit,
// B signed 8-bit and C 32-bit wrapping, held in three single-port-read RAMs.
// Input stream (s_*): one beat per element write, C read or compute request;
// tuser carries the operation, tdata the indices and values.
// Output stream (m_*): one beat per C read, per out-of-range element access
// and per finished compute; tuser carries the result kind.
// Config channel (cfg_*): always ready; write only while the block is idle.
// Throughput: element writes and reads are taken one per cycle while the result
// path has room. A read or an error answer passes the pending stage and the
// output register on its way to m_*. A compute holds s_tready low until its done
// beat enters the pending stage: one A and one B RAM read per cycle, one
// multiply-accumulate per cycle, C read and written back once per entry at the end of its depth walk.
// Reset clears the handshake state and loads the sizes 16, 16, 64 and
// overwrite mode; the stores hold nothing defined until written.
// When the receiver stalls, the output register holds its beat and one more
// answer waits in a pending stage; after that s_tready drops.
`default_nettype none

module int8_matrix_multiply (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: row_index[5:0], col_index[11:6], a_value[19:12], b_value[27:20],
  //          c_value[59:28], zero fill [63:60]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,
  // s_tuser: operation[2:0]
  input  wire logic [2:0]  s_tuser,
  // m_tdata: result_value[31:0], status[32], zero fill [39:33]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,
  // m_tuser: result_kind[0]
  output logic             m_tuser,
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire imm_pkg::cfg_index_t cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import imm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;

  // Configuration registers
  logic [4:0] row_count;
  logic [4:0] column_count;
  logic [6:0] inner_depth;
  logic       accumulate_mode;
  dims_t      dims;

  // Input beat fields
  op_t          op;
  logic [5:0]   row_idx;
  logic [5:0]   col_idx;
  logic [7:0]   a_val;
  logic [7:0]   b_val;
  logic [31:0]  c_val;
  logic         accept;

  // Range checks and item decode
  logic r_lt_rows, r_lt_depth, c_lt_cols, c_lt_depth;
  logic a_ok, b_ok, c_ok;
  logic has_res, res_status, res_from_c;

  // Stores
  a_addr_t     a_waddr, a_raddr;
  b_addr_t     b_waddr, b_raddr;
  c_addr_t     c_item_addr, c_waddr, c_raddr;
  logic        a_we, b_we, c_we, c_re;
  logic [31:0] c_wdata;
  logic [7:0]  a_rd, b_rd;
  logic [31:0] c_rd;

  // Compute pipeline
  logic               start;
  walk_tag_t          tag, s1, s2;
  logic signed [16:0] prod;
  logic [31:0]        acc, acc_next, c_sum;

  // Result path
  logic        p_valid, p_kind, p_status, p_from_c;
  logic        o_valid, o_kind, o_status;
  logic [31:0] o_value;
  logic        adv, slot_free;

  assign op      = op_t'(s_tuser);
  assign row_idx = s_tdata[5:0];
  assign col_idx = s_tdata[11:6];
  assign a_val   = s_tdata[19:12];
  assign b_val   = s_tdata[27:20];
  assign c_val   = s_tdata[59:28];

  // ------------------------------------------------------------------
  // Configuration: sizes are clamped to 1..bound before use
  // ------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= 5'd16;
      column_count    <= 5'd16;
      inner_depth     <= 7'd64;
      accumulate_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count       <= cfg_data[4:0];
        REG_COLUMN_COUNT: column_count    <= cfg_data[4:0];
        REG_INNER_DEPTH:  inner_depth     <= cfg_data;
        REG_ACCUM_MODE:   accumulate_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign dims.rows  = ROWS_SW'(clamp_size({2'd0, row_count}, 16'(MAX_ROWS)));
  assign dims.cols  = COLS_SW'(clamp_size({2'd0, column_count}, 16'(MAX_COLS)));
  assign dims.depth = DEPTH_SW'(clamp_size(inner_depth, 16'(MAX_DEPTH)));

  assign r_lt_rows  = 16'(row_idx) < 16'(dims.rows);
  assign r_lt_depth = 16'(row_idx) < 16'(dims.depth);
  assign c_lt_cols  = 16'(col_idx) < 16'(dims.cols);
  assign c_lt_depth = 16'(col_idx) < 16'(dims.depth);

  assign a_ok = r_lt_rows && c_lt_depth;
  assign b_ok = r_lt_depth && c_lt_cols;
  assign c_ok = r_lt_rows && c_lt_cols;

  // Which items answer on the output stream, and how
  always_comb begin
    has_res    = 1'b0;
    res_status = STATUS_OK;
    res_from_c = 1'b0;
    case (op)
      OP_WRITE_A: begin
        has_res    = !a_ok;
        res_status = STATUS_RANGE;
      end
      OP_WRITE_B: begin
        has_res    = !b_ok;
        res_status = STATUS_RANGE;
      end
      OP_WRITE_C: begin
        has_res    = !c_ok;
        res_status = STATUS_RANGE;
      end
      OP_READ_C: begin
        has_res    = 1'b1;
        res_status = c_ok ? STATUS_OK : STATUS_RANGE;
        res_from_c = c_ok;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // Handshake and sequencing
  // ------------------------------------------------------------------
  assign adv       = p_valid && (!o_valid || m_tready);
  assign slot_free = !p_valid || adv;
  assign s_tready  = (state == ST_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;
  assign start     = accept && (op == OP_COMPUTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          // Last product written back: the compute is complete
          if (s2.valid && s2.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  imm_walk u_walk (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .dims   (dims),
    .tag    (tag),
    .a_addr (a_raddr),
    .b_addr (b_raddr)
  );

  // ------------------------------------------------------------------
  // Stores
  // ------------------------------------------------------------------
  assign a_we        = accept && (op == OP_WRITE_A) && a_ok;
  assign b_we        = accept && (op == OP_WRITE_B) && b_ok;
  assign a_waddr     = a_index(16'(row_idx), 16'(col_idx));
  assign b_waddr     = b_index(16'(row_idx), 16'(col_idx));
  assign c_item_addr = c_index(16'(row_idx), 16'(col_idx));

  // C is shared by item accesses (idle) and the compute write-back (busy)
  assign c_we    = (accept && (op == OP_WRITE_C) && c_ok) || (s2.valid && s2.last);
  assign c_waddr = s2.valid ? s2.c_addr : c_item_addr;
  assign c_wdata = s2.valid ? c_sum : c_val;
  assign c_re    = (accept && (op == OP_READ_C) && c_ok) || (s1.valid && s1.last);
  assign c_raddr = s1.valid ? s1.c_addr : c_item_addr;

  imm_ram #(.WIDTH(8), .DEPTH(A_DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_val),
    .re    (tag.valid),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  imm_ram #(.WIDTH(8), .DEPTH(B_DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_val),
    .re    (tag.valid),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  imm_ram #(.WIDTH(32), .DEPTH(C_DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rd)
  );

  // ------------------------------------------------------------------
  // Multiply-accumulate pipeline
  //   issue : walker drives A/B read addresses
  //   s1    : A/B data out of RAM, multiply; C read issued on last product
  //   s2    : accumulate; on last product add old C (accumulate mode) and
  //           write the entry back
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else begin
      s1.valid <= tag.valid;
      s2.valid <= s1.valid;
    end
    s1.first  <= tag.first;
    s1.last   <= tag.last;
    s1.done   <= tag.done;
    s1.c_addr <= tag.c_addr;
    s2.first  <= s1.first;
    s2.last   <= s1.last;
    s2.done   <= s1.done;
    s2.c_addr <= s1.c_addr;
    prod      <= $signed({1'b0, a_rd}) * $signed(b_rd);
    if (s2.valid) begin
      acc <= acc_next;
    end
  end

  assign acc_next = (s2.first ? 32'd0 : acc) + 32'(prod);
  assign c_sum    = acc_next + (accumulate_mode ? c_rd : 32'd0);

  // ------------------------------------------------------------------
  // Result path: pending stage, then output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept && has_res) begin
      p_valid <= 1'b1;
    end else if ((state == ST_FINISH) && slot_free) begin
      p_valid <= 1'b1;
    end else if (adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      p_kind   <= KIND_READ;
      p_status <= res_status;
      p_from_c <= res_from_c;
    end else if ((state == ST_FINISH) && slot_free) begin
      p_kind   <= KIND_DONE;
      p_status <= STATUS_OK;
      p_from_c <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  // Read data sits in the C RAM output register until the beat advances
  always_ff @(posedge clk) begin
    if (adv) begin
      o_kind   <= p_kind;
      o_status <= p_status;
      o_value  <= p_from_c ? c_rd : 32'd0;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {7'd0, o_status, o_value};
  assign m_tuser  = o_kind;

endmodule

`default_nettype wire
